// ===== sv/pnfo_pkg.sv =====
// pnfo_pkg: shared widths, register index codes and unit control types
// for the flux observer core. no dependencies.
`default_nettype none

package pnfo_pkg;

   localparam int DataW    = 32;   // q8.24 data words
   localparam int CfgW     = 31;   // unsigned coefficient registers
   localparam int OpW      = 33;   // signed multiplier operand
   localparam int ProdW    = 64;   // kept product bits
   localparam int SumW     = 52;   // rounded product plus base, headroom for q20.12
   localparam int CsrIdxW  = 3;
   localparam int Q24Frac  = 24;
   localparam int Q12Frac  = 12;

   localparam logic signed [DataW-1:0] TangentGainRst = 32'sd16777216;
   localparam logic signed [DataW-1:0] Max32 = 32'sh7FFF_FFFF;
   localparam logic signed [DataW-1:0] Min32 = 32'sh8000_0000;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_INDUCTANCE = 3'd0,
      CSR_RESISTANCE = 3'd1,
      CSR_PERIOD     = 3'd2,
      CSR_FLUX       = 3'd3,
      CSR_GAIN       = 3'd4,
      CSR_TANGENT    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [OpW-1:0]  mul_a;
      logic signed [OpW-1:0]  mul_b;
      logic                   shift12;
      logic                   subtract;
      logic signed [SumW-1:0] base;
   } alu_ctl_type;

   typedef struct packed {
      logic signed [SumW-1:0]  sum;
      logic signed [DataW-1:0] clipped;
      logic                    clip;
   } alu_res_type;

endpackage

`default_nettype wire

// ===== sv/pnfo_req_if.sv =====
// pnfo_req_if: sample channel into the flux observer core
// depends on nothing
`default_nettype none

interface pnfo_req_if;
   logic               valid;
   logic               ready;
   logic               mode;
   logic signed [31:0] volt_alpha;
   logic signed [31:0] volt_beta;
   logic signed [31:0] curr_alpha;
   logic signed [31:0] curr_beta;
   logic               speed_positive;

   modport source (output valid, mode, volt_alpha, volt_beta, curr_alpha, curr_beta,
                   speed_positive, input ready);
   modport sink (input valid, mode, volt_alpha, volt_beta, curr_alpha, curr_beta,
                 speed_positive, output ready);
endinterface

`default_nettype wire

// ===== sv/pnfo_rsp_if.sv =====
// pnfo_rsp_if: rotor flux result channel out of the flux observer core
// depends on nothing
`default_nettype none

interface pnfo_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] rotor_flux_alpha;
   logic signed [31:0] rotor_flux_beta;
   logic               saturated;

   modport source (output valid, rotor_flux_alpha, rotor_flux_beta, saturated,
                   input ready);
   modport sink (input valid, rotor_flux_alpha, rotor_flux_beta, saturated,
                 output ready);
endinterface

`default_nettype wire

// ===== sv/pmsm_nonlinear_flux_observer_core.sv =====
// pmsm_nonlinear_flux_observer_core: nonlinear stator flux observer, top level
// depends on pnfo_pkg, pnfo_req_if, pnfo_rsp_if and pnfo_alu
//
//   channel   | direction | beat contents
//   ----------+-----------+--------------------------------------------------
//   req_bus   | in        | mode, volt/curr alpha and beta, speed_positive
//   rsp_bus   | out       | rotor_flux_alpha, rotor_flux_beta, saturated
//   csr_*     | in        | write enable, register index, 32 bit write data
//
// an observer beat runs fifteen micro-steps through the one shared multiplier,
// each as a multiply state then an accumulate state, between the accept and
// a hand-over state that waits for the output register to be free.
// a reinitialise beat goes straight to hand-over. the multiplier is the pacing unit.
// req_bus.ready is high only while the sequencer is idle; the result sits in
// its own output register, so a new beat may enter while it waits.
// synchronous reset clears the stator flux and the registers to defaults.
`default_nettype none

module pmsm_nonlinear_flux_observer_core (
   input  logic                             clock,
   input  logic                             reset,
   pnfo_req_if.sink                         req_bus,
   pnfo_rsp_if.source                       rsp_bus,
   input  logic                             csr_wr_en,
   input  logic [pnfo_pkg::CsrIdxW-1:0]     csr_index,
   input  logic [pnfo_pkg::DataW-1:0]       csr_wr_data
);
   import pnfo_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_MUL, S_ACC, S_DONE} state_type;

   // micro-step order of one observer update
   typedef enum logic [3:0] {
      ST_RA, ST_RB, ST_TA, ST_TB, ST_FF, ST_RRA, ST_RRB,
      ST_GA, ST_CA, ST_DA, ST_PSA, ST_GB, ST_CB, ST_DB, ST_PSB
   } step_type;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;

   // configuration registers
   logic [CfgW-1:0]         ls_ff, rs_ff, ts_ff, flux_ff, gain_ff;
   logic signed [DataW-1:0] kt_ff;

   // observer state and per-beat working registers
   logic signed [DataW-1:0] psi_a_ff, psi_b_ff;
   logic signed [DataW-1:0] ra_ff, rb_ff, ta_ff, tb_ff, err_ff, g_ff, d_ff;
   logic signed [DataW-1:0] va_ff, vb_ff, ia_ff, ib_ff;
   logic signed [OpW-1:0]   ks_ff;
   logic signed [SumW-1:0]  acc_ff;
   logic                    flag_ff;

   // output register
   logic                    rsp_valid_ff;
   logic signed [DataW-1:0] rsp_ra_ff, rsp_rb_ff;
   logic                    rsp_sat_ff;

   alu_ctl_type             alu_ctl;
   alu_res_type             alu_res;
   logic                    req_fire;
   logic                    out_free;
   logic signed [OpW-1:0]   kt_wide;

   function automatic logic signed [OpW-1:0] from_cfg(input logic [CfgW-1:0] x);
      return $signed({2'b00, x});
   endfunction

   function automatic logic signed [OpW-1:0] from_dat(input logic signed [DataW-1:0] x);
      return $signed({x[DataW-1], x});
   endfunction

   function automatic logic signed [SumW-1:0] widen(input logic signed [DataW-1:0] x);
      return SumW'(x);
   endfunction

   assign req_bus.ready            = (state_ff == S_IDLE);
   assign req_fire                 = req_bus.valid && (state_ff == S_IDLE);
   assign out_free                 = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.rotor_flux_alpha = rsp_ra_ff;
   assign rsp_bus.rotor_flux_beta  = rsp_rb_ff;
   assign rsp_bus.saturated        = rsp_sat_ff;
   assign kt_wide                  = from_dat(kt_ff);

   // operand and base selection for the current micro-step
   always_comb begin
      alu_ctl = '0;
      unique case (step_ff)
         ST_RA: begin   // psi_a - Ls*i_a
            alu_ctl.mul_a = from_cfg(ls_ff);   alu_ctl.mul_b = from_dat(ia_ff);
            alu_ctl.subtract = 1'b1;           alu_ctl.base = widen(psi_a_ff);
         end
         ST_RB: begin
            alu_ctl.mul_a = from_cfg(ls_ff);   alu_ctl.mul_b = from_dat(ib_ff);
            alu_ctl.subtract = 1'b1;           alu_ctl.base = widen(psi_b_ff);
         end
         ST_TA: begin   // tangential rotation, alpha
            alu_ctl.mul_a = ks_ff;             alu_ctl.mul_b = from_dat(rb_ff);
            alu_ctl.subtract = 1'b1;           alu_ctl.base = widen(ra_ff);
         end
         ST_TB: begin
            alu_ctl.mul_a = ks_ff;             alu_ctl.mul_b = from_dat(ra_ff);
            alu_ctl.base = widen(rb_ff);
         end
         ST_FF: begin   // magnitude error starts from F squared
            alu_ctl.mul_a = from_cfg(flux_ff); alu_ctl.mul_b = from_cfg(flux_ff);
         end
         ST_RRA: begin
            alu_ctl.mul_a = from_dat(ra_ff);   alu_ctl.mul_b = from_dat(ra_ff);
            alu_ctl.subtract = 1'b1;           alu_ctl.base = acc_ff;
         end
         ST_RRB: begin
            alu_ctl.mul_a = from_dat(rb_ff);   alu_ctl.mul_b = from_dat(rb_ff);
            alu_ctl.subtract = 1'b1;           alu_ctl.base = acc_ff;
         end
         ST_GA: begin   // gain is q20.12
            alu_ctl.mul_a = from_cfg(gain_ff); alu_ctl.mul_b = from_dat(ta_ff);
            alu_ctl.shift12 = 1'b1;
         end
         ST_CA: begin   // psi_a plus correction, held wide
            alu_ctl.mul_a = from_dat(g_ff);    alu_ctl.mul_b = from_dat(err_ff);
            alu_ctl.base = widen(psi_a_ff);
         end
         ST_DA: begin   // v_a - Rs*i_a
            alu_ctl.mul_a = from_cfg(rs_ff);   alu_ctl.mul_b = from_dat(ia_ff);
            alu_ctl.subtract = 1'b1;           alu_ctl.base = widen(va_ff);
         end
         ST_PSA: begin
            alu_ctl.mul_a = from_cfg(ts_ff);   alu_ctl.mul_b = from_dat(d_ff);
            alu_ctl.base = acc_ff;
         end
         ST_GB: begin
            alu_ctl.mul_a = from_cfg(gain_ff); alu_ctl.mul_b = from_dat(tb_ff);
            alu_ctl.shift12 = 1'b1;
         end
         ST_CB: begin
            alu_ctl.mul_a = from_dat(g_ff);    alu_ctl.mul_b = from_dat(err_ff);
            alu_ctl.base = widen(psi_b_ff);
         end
         ST_DB: begin
            alu_ctl.mul_a = from_cfg(rs_ff);   alu_ctl.mul_b = from_dat(ib_ff);
            alu_ctl.subtract = 1'b1;           alu_ctl.base = widen(vb_ff);
         end
         ST_PSB: begin
            alu_ctl.mul_a = from_cfg(ts_ff);   alu_ctl.mul_b = from_dat(d_ff);
            alu_ctl.base = acc_ff;
         end
         default: begin
            alu_ctl = '0;
         end
      endcase
   end

   pnfo_alu u_alu (
      .clock  (clock),
      .mul_en (state_ff == S_MUL),
      .ctl    (alu_ctl),
      .res    (alu_res)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               step_in  = ST_RA;
               state_in = req_bus.mode ? S_DONE : S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            if (step_ff == ST_PSB) begin
               state_in = S_DONE;
            end else begin
               step_in  = step_type'(step_ff + 4'd1);
               state_in = S_MUL;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= ST_RA;
         rsp_valid_ff <= 1'b0;
         ls_ff        <= '0;
         rs_ff        <= '0;
         ts_ff        <= '0;
         flux_ff      <= '0;
         gain_ff      <= '0;
         kt_ff        <= TangentGainRst;
         psi_a_ff     <= '0;
         psi_b_ff     <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;

         if (csr_wr_en) begin
            unique case (csr_index_type'(csr_index))
               CSR_INDUCTANCE: ls_ff   <= csr_wr_data[CfgW-1:0];
               CSR_RESISTANCE: rs_ff   <= csr_wr_data[CfgW-1:0];
               CSR_PERIOD:     ts_ff   <= csr_wr_data[CfgW-1:0];
               CSR_FLUX:       flux_ff <= csr_wr_data[CfgW-1:0];
               CSR_GAIN:       gain_ff <= csr_wr_data[CfgW-1:0];
               CSR_TANGENT:    kt_ff   <= $signed(csr_wr_data);
               default:        ;   // indexes past the list are dropped
            endcase
         end

         // output register: load on hand-over, clear when the beat is taken
         if (state_ff == S_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_ra_ff    <= ra_ff;
            rsp_rb_ff    <= rb_ff;
            rsp_sat_ff   <= flag_ff;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (req_fire) begin
            va_ff   <= req_bus.volt_alpha;
            vb_ff   <= req_bus.volt_beta;
            ia_ff   <= req_bus.curr_alpha;
            ib_ff   <= req_bus.curr_beta;
            // sign of k follows the speed command, negation done 33 bits wide
            ks_ff   <= req_bus.speed_positive ? kt_wide : -kt_wide;
            flag_ff <= 1'b0;
            if (req_bus.mode) begin
               // reinitialise: flux back to (F, 0), result all zero
               psi_a_ff <= $signed({1'b0, flux_ff});
               psi_b_ff <= '0;
               ra_ff    <= '0;
               rb_ff    <= '0;
            end
         end

         // write-back of the micro-step result
         if (state_ff == S_ACC) begin
            unique case (step_ff)
               ST_RA:  begin ra_ff    <= alu_res.clipped; flag_ff <= flag_ff | alu_res.clip; end
               ST_RB:  begin rb_ff    <= alu_res.clipped; flag_ff <= flag_ff | alu_res.clip; end
               ST_TA:  begin ta_ff    <= alu_res.clipped; flag_ff <= flag_ff | alu_res.clip; end
               ST_TB:  begin tb_ff    <= alu_res.clipped; flag_ff <= flag_ff | alu_res.clip; end
               ST_FF:  acc_ff <= alu_res.sum;
               ST_RRA: acc_ff <= alu_res.sum;
               ST_RRB: begin err_ff   <= alu_res.clipped; flag_ff <= flag_ff | alu_res.clip; end
               ST_GA:  begin g_ff     <= alu_res.clipped; flag_ff <= flag_ff | alu_res.clip; end
               ST_CA:  acc_ff <= alu_res.sum;
               ST_DA:  begin d_ff     <= alu_res.clipped; flag_ff <= flag_ff | alu_res.clip; end
               ST_PSA: begin psi_a_ff <= alu_res.clipped; flag_ff <= flag_ff | alu_res.clip; end
               ST_GB:  begin g_ff     <= alu_res.clipped; flag_ff <= flag_ff | alu_res.clip; end
               ST_CB:  acc_ff <= alu_res.sum;
               ST_DB:  begin d_ff     <= alu_res.clipped; flag_ff <= flag_ff | alu_res.clip; end
               ST_PSB: begin psi_b_ff <= alu_res.clipped; flag_ff <= flag_ff | alu_res.clip; end
               default: ;
            endcase
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/pnfo_alu.sv =====
// pnfo_alu: shared multiply, round, add and saturate unit
// depends on pnfo_pkg
`default_nettype none

module pnfo_alu (
   input  logic                  clock,
   input  logic                  mul_en,
   input  pnfo_pkg::alu_ctl_type ctl,
   output pnfo_pkg::alu_res_type res
);
   import pnfo_pkg::*;

   localparam logic signed [ProdW-1:0] Half24 = ProdW'(1) <<< (Q24Frac - 1);
   localparam logic signed [ProdW-1:0] Half12 = ProdW'(1) <<< (Q12Frac - 1);

   logic signed [OpW-1:0]   op_a;
   logic signed [OpW-1:0]   op_b;
   logic signed [2*OpW-1:0] full_prod;
   logic signed [ProdW-1:0] prod_ff;
   logic signed [ProdW-1:0] prod_in;
   logic signed [ProdW-1:0] rnd24;
   logic signed [ProdW-1:0] rnd12;
   logic signed [SumW-1:0]  rounded;
   logic signed [SumW-1:0]  sum;
   logic                    clip_hi;
   logic                    clip_lo;

   always_comb begin
      op_a      = ctl.mul_a;
      op_b      = ctl.mul_b;
      full_prod = op_a * op_b;
      // product magnitude stays within 2^62, the low 64 bits hold it exactly
      prod_in   = mul_en ? $signed(full_prod[ProdW-1:0]) : prod_ff;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   always_comb begin
      // round half up, then floor
      rnd24   = (prod_ff + Half24) >>> Q24Frac;
      rnd12   = (prod_ff + Half12) >>> Q12Frac;
      rounded = ctl.shift12 ? SumW'(rnd12) : SumW'(rnd24);
      sum     = ctl.subtract ? ctl.base - rounded : ctl.base + rounded;
      clip_hi = !sum[SumW-1] && (|sum[SumW-2:DataW-1]);
      clip_lo = sum[SumW-1] && !(&sum[SumW-2:DataW-1]);
      res.sum = sum;
      res.clip = clip_hi || clip_lo;
      if (clip_hi) begin
         res.clipped = Max32;
      end else if (clip_lo) begin
         res.clipped = Min32;
      end else begin
         res.clipped = sum[DataW-1:0];
      end
   end

endmodule

`default_nettype wire

// ===== sv/pnfo_checker.sv =====
// pnfo_checker: port-level assertions for the flux observer core, with bind
// depends on pmsm_nonlinear_flux_observer_core
`default_nettype none

module pnfo_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_ra,
   input logic [31:0] rsp_rb,
   input logic        rsp_sat
);
   logic [1:0] pend_ff;
   logic [1:0] pend_in;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff;
      if (req_fire && !rsp_fire) begin
         pend_in = pend_ff + 2'd1;
      end else if (rsp_fire && !req_fire) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 2'd0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // a waiting result beat holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ra) && $stable(rsp_rb)
                                  && $stable(rsp_sat))
      else $error("result beat changed while stalled");

   // one beat at a time in the sequencer
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("ready high right after an accepted beat");

   // no result without an outstanding request
   a_no_orphan_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result beat with no request outstanding");

   // one beat in the output register and one in work is the limit
   a_depth_limit: assert property (@(posedge clock) disable iff (reset)
      pend_ff == 2'd2 |-> !req_ready)
      else $error("ready while two beats outstanding");

endmodule

bind pmsm_nonlinear_flux_observer_core pnfo_checker u_pnfo_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_ra    (rsp_bus.rotor_flux_alpha),
   .rsp_rb    (rsp_bus.rotor_flux_beta),
   .rsp_sat   (rsp_bus.saturated)
);

`default_nettype wire

// ===== tb/sv/pnfo_flux_checker.sv =====
// pnfo_flux_checker: watches the sample, result and register ports of the flux
// observer core, predicts each rotor flux beat and compares it field by field
// depends on pnfo_pkg, pnfo_req_if and pnfo_rsp_if
`timescale 1ns / 100ps

module pnfo_flux_checker (
   input  logic                          clock,
   input  logic                          reset,
   pnfo_req_if                           req_mon,
   pnfo_rsp_if                           rsp_mon,
   input  logic                          csr_wr_en,
   input  logic [pnfo_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [pnfo_pkg::DataW-1:0]    csr_wr_data,
   output int                            mismatches,
   output int                            pending
);
   import pnfo_pkg::*;

   typedef struct {
      logic signed [DataW-1:0] alpha;
      logic signed [DataW-1:0] beta;
      logic                    clipped;
   } rotor_flux_type;

   // coefficients, kept zero-extended (or sign-extended for the tangent gain)
   longint ls_coef, rs_coef, ts_coef, flux_ref, corr_gain, tang_gain;
   logic signed [DataW-1:0] psi_a, psi_b;
   logic clip_seen;
   rotor_flux_type rotor_flux_q[$];

   initial mismatches = 0;
   initial pending = 0;

   function automatic longint round_shift(input longint p, input int s);
      return (p + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic logic signed [DataW-1:0] clip32(input longint v);
      if (v > longint'(Max32)) begin
         clip_seen = 1'b1;
         return Max32;
      end
      if (v < longint'(Min32)) begin
         clip_seen = 1'b1;
         return Min32;
      end
      return v[DataW-1:0];
   endfunction

   // one axis of the flux update: back-emf integration plus magnitude correction
   function automatic logic signed [DataW-1:0] advance_flux(
      input logic signed [DataW-1:0] psi, volt, curr, tang, err);
      longint g, corr, drop, incr;
      g    = clip32(round_shift(corr_gain * longint'(tang), Q12Frac));
      corr = round_shift(g * longint'(err), Q24Frac);
      drop = clip32(longint'(volt) - round_shift(rs_coef * longint'(curr), Q24Frac));
      incr = round_shift(ts_coef * drop, Q24Frac);
      return clip32(longint'(psi) + incr + corr);
   endfunction

   task automatic predict_beat();
      longint ks;
      logic signed [DataW-1:0] ra, rb, ta, tb, err;
      rotor_flux_type res;
      clip_seen = 1'b0;
      if (req_mon.mode) begin
         psi_a = flux_ref[DataW-1:0];
         psi_b = '0;
         res = '{alpha: '0, beta: '0, clipped: 1'b0};
      end else begin
         ks = req_mon.speed_positive ? tang_gain : -tang_gain;
         ra = clip32(longint'(psi_a)
                     - round_shift(ls_coef * longint'(req_mon.curr_alpha), Q24Frac));
         rb = clip32(longint'(psi_b)
                     - round_shift(ls_coef * longint'(req_mon.curr_beta), Q24Frac));
         ta = clip32(longint'(ra) - round_shift(ks * longint'(rb), Q24Frac));
         tb = clip32(longint'(rb) + round_shift(ks * longint'(ra), Q24Frac));
         err = clip32(round_shift(flux_ref * flux_ref, Q24Frac)
                      - round_shift(longint'(ra) * longint'(ra), Q24Frac)
                      - round_shift(longint'(rb) * longint'(rb), Q24Frac));
         psi_a = advance_flux(psi_a, req_mon.volt_alpha, req_mon.curr_alpha, ta, err);
         psi_b = advance_flux(psi_b, req_mon.volt_beta, req_mon.curr_beta, tb, err);
         res = '{alpha: ra, beta: rb, clipped: clip_seen};
      end
      rotor_flux_q.push_back(res);
   endtask

   function automatic void check_field(input string name, input longint want, got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : watch
      rotor_flux_type want;
      if (reset) begin
         ls_coef   = 0;
         rs_coef   = 0;
         ts_coef   = 0;
         flux_ref  = 0;
         corr_gain = 0;
         tang_gain = longint'(TangentGainRst);
         psi_a     = '0;
         psi_b     = '0;
         rotor_flux_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_INDUCTANCE: ls_coef   = longint'(csr_wr_data[CfgW-1:0]);
               CSR_RESISTANCE: rs_coef   = longint'(csr_wr_data[CfgW-1:0]);
               CSR_PERIOD:     ts_coef   = longint'(csr_wr_data[CfgW-1:0]);
               CSR_FLUX:       flux_ref  = longint'(csr_wr_data[CfgW-1:0]);
               CSR_GAIN:       corr_gain = longint'(csr_wr_data[CfgW-1:0]);
               CSR_TANGENT:    tang_gain = longint'(signed'(csr_wr_data));
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            predict_beat();
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (rotor_flux_q.size() == 0) begin
               $error("rotor flux beat with no sample waiting for it");
               mismatches++;
            end else begin
               want = rotor_flux_q.pop_front();
               check_field("rotor_flux_alpha", want.alpha, rsp_mon.rotor_flux_alpha);
               check_field("rotor_flux_beta", want.beta, rsp_mon.rotor_flux_beta);
               check_field("saturated", want.clipped, rsp_mon.saturated);
            end
         end
      end
      pending <= rotor_flux_q.size();
   end

endmodule

// ===== tb/sv/pmsm_nonlinear_flux_observer_core_test.sv =====
// pmsm_nonlinear_flux_observer_core_test: drives samples and register writes
// into the flux observer core and gives the verdict from the checker's count
// depends on pnfo_pkg, pnfo_req_if, pnfo_rsp_if, pnfo_flux_checker and the core
`timescale 1ns / 100ps

module pmsm_nonlinear_flux_observer_core_test;
   import pnfo_pkg::*;

   localparam int ResetCycles = 9;
   localparam int CycleLimit  = 1000000;   // several times the slowest legal run
   localparam int TailCycles  = 64;        // idle time before the verdict
   localparam int LongHold    = 600;       // receiver hold-off
   localparam int PhaseCount  = 8;
   localparam int PhaseBeats  = 150;
   localparam int PausePhase  = 5;
   localparam int VoltSpan    = 838860800;  // 50 V in q8.24
   localparam int CurrSpan    = 335544320;  // 20 A in q8.24

   // indexes past the register list, which the core must ignore
   localparam logic [CsrIdxW-1:0] SpareIdxA = 3'd6;
   localparam logic [CsrIdxW-1:0] SpareIdxB = 3'd7;

   typedef struct {
      logic                    mode;
      logic signed [DataW-1:0] va;
      logic signed [DataW-1:0] vb;
      logic signed [DataW-1:0] ia;
      logic signed [DataW-1:0] ib;
      logic                    spd;
   } sample_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CsrIdxW-1:0] csr_index;
   logic [DataW-1:0] csr_wr_data;
   int mismatches;
   int pending;
   int burst_left = 0;
   int hold_asks = 0;
   int cycle_count = 0;

   pnfo_req_if req_bus ();
   pnfo_rsp_if rsp_bus ();

   pmsm_nonlinear_flux_observer_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // checker sits beside the core and sees exactly what the core sees
   pnfo_flux_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .mismatches  (mismatches),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run as a failure
   initial begin : watchdog
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // any magnitude from full scale down to a few lsbs, so every bit toggles
   function automatic logic signed [DataW-1:0] wide_word();
      logic signed [DataW-1:0] w;
      w = $urandom();
      return w >>> $urandom_range(0, DataW - 1);
   endfunction

   // plausible motor quantity, uniform in +/- lim
   function automatic logic signed [DataW-1:0] span_word(input int lim);
      return int'($urandom_range(0, 2 * lim)) - lim;
   endfunction

   // 31 bit coefficient with random magnitude; bit 31 is junk the core must drop
   function automatic logic [DataW-1:0] coef_word();
      logic [DataW-1:0] w;
      w = $urandom();
      w[CfgW-1:0] = w[CfgW-1:0] >> $urandom_range(0, CfgW - 1);
      return w;
   endfunction

   function automatic sample_type make_sample(input logic reinit, input logic tame);
      sample_type s;
      s.mode = reinit;
      s.spd  = $urandom_range(0, 1);
      if (tame) begin
         s.va = span_word(VoltSpan);
         s.vb = span_word(VoltSpan);
         s.ia = span_word(CurrSpan);
         s.ib = span_word(CurrSpan);
      end else begin
         s.va = wide_word();
         s.vb = wide_word();
         s.ia = wide_word();
         s.ib = wide_word();
      end
      return s;
   endfunction

   // one sample beat; bursts of random length with random gaps between them
   task automatic offer_beat(input sample_type s);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid          <= 1'b1;
      req_bus.mode           <= s.mode;
      req_bus.volt_alpha     <= s.va;
      req_bus.volt_beta      <= s.vb;
      req_bus.curr_alpha     <= s.ia;
      req_bus.curr_beta      <= s.ib;
      req_bus.speed_positive <= s.spd;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // first edge lets the checker count a beat accepted at the calling edge
   task automatic wait_idle();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic csr_put(input logic [CsrIdxW-1:0] idx, input logic [DataW-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
   endtask

   // full register set, plus writes to the spare indexes that must change nothing
   task automatic program_regs(input logic [DataW-1:0] ls, rs, ts, fl, gn, tg);
      csr_put(CSR_INDUCTANCE, ls);
      csr_put(SpareIdxA, $urandom());
      csr_put(CSR_RESISTANCE, rs);
      csr_put(CSR_PERIOD, ts);
      csr_put(CSR_FLUX, fl);
      csr_put(SpareIdxB, $urandom());
      csr_put(CSR_GAIN, gn);
      csr_put(CSR_TANGENT, tg);
      csr_wr_en <= 1'b0;
   endtask

   // receiver: stall style changes every so often, with an occasional long
   // hold-off so results back up and the core stops taking samples
   initial begin : rsp_sink
      int style, left, hold_seen, hold_left;
      rsp_bus.ready <= 1'b0;
      style = 0;
      left = 0;
      hold_seen = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = LongHold;
         end
         if (left == 0) begin
            style = $urandom_range(0, 3);
            left  = $urandom_range(1, 200);
         end
         left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (style)
               0: rsp_bus.ready <= 1'b1;                          // no stalls
               1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);   // light stalls
               2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);   // heavy stalls
               default: rsp_bus.ready <= ((left % 5) == 0);       // periodic
            endcase
         end
      end
   end

   initial begin : stimulus
      int phase, n, run_left;
      logic tame;
      logic signed [DataW-1:0] tg;
      req_bus.valid          <= 1'b0;
      req_bus.mode           <= 1'b0;
      req_bus.volt_alpha     <= '0;
      req_bus.volt_beta      <= '0;
      req_bus.curr_alpha     <= '0;
      req_bus.curr_beta      <= '0;
      req_bus.speed_positive <= 1'b0;
      csr_wr_en              <= 1'b0;
      csr_index              <= CSR_INDUCTANCE;
      csr_wr_data            <= '0;
      reset                  <= 1'b1;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: all coefficients zero, tangent gain one
      offer_beat('{1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b1});
      offer_beat('{1'b0, Max32, Max32, Max32, Max32, 1'b0});
      offer_beat('{1'b0, Min32, Min32, Min32, Min32, 1'b1});
      offer_beat('{1'b1, Max32, Min32, Max32, Min32, 1'b1});
      req_bus.valid <= 1'b0;
      wait_idle();

      // typical motor: 1 mH, 0.5 ohm, 100 us, 0.1 Wb, gain 10, tangent gain two
      program_regs(32'd16777, 32'd8388608, 32'd1678, 32'd1677722, 32'd40960,
                   32'd33554432);
      offer_beat('{1'b1, Max32, Max32, Min32, Min32, 1'b0});  // reinitialise ignores fields
      offer_beat('{1'b0, 32'sd167772160, -32'sd83886080, 32'sd16777216, 32'sd0, 1'b1});
      offer_beat('{1'b0, -32'sd167772160, 32'sd83886080, 32'sd0, -32'sd16777216, 1'b0});
      offer_beat('{1'b0, 32'sd0, 32'sd0, 32'sd33554432, 32'sd33554432, 1'b1});
      offer_beat('{1'b0, 32'sd100, -32'sd100, -32'sd1, 32'sd1, 1'b0});
      req_bus.valid <= 1'b0;
      wait_idle();

      // extremes: full-scale coefficients with junk in bit 31, and the most
      // negative tangent gain, whose negation for negative speed must be exact
      program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, Min32);
      offer_beat('{1'b0, 32'sd0, 32'sd0, Max32, Max32, 1'b0});
      offer_beat('{1'b0, 32'sd0, 32'sd0, Min32, Min32, 1'b1});
      offer_beat('{1'b1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0});
      offer_beat('{1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0});
      offer_beat('{1'b0, Max32, Max32, Min32, Min32, 1'b1});
      offer_beat('{1'b0, Min32, Min32, Max32, Max32, 1'b0});
      req_bus.valid <= 1'b0;
      wait_idle();

      // only flux and the largest positive tangent gain
      program_regs(32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'd0, Max32);
      offer_beat('{1'b1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b1});
      offer_beat('{1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b1});
      offer_beat('{1'b0, Max32, Min32, Max32, Min32, 1'b0});
      req_bus.valid <= 1'b0;
      wait_idle();

      // random phases, each under its own register setting
      for (phase = 0; phase < PhaseCount; phase++) begin
         tame = 1'b0;
         case (phase % 4)
            0, 1: begin
               tg = $urandom_range(8388608, 33554432);
               if ($urandom_range(0, 1) == 1) tg = -tg;
               program_regs($urandom_range(1000, 200000), $urandom_range(167772, 33554432),
                            $urandom_range(100, 2000), $urandom_range(167772, 8388608),
                            $urandom_range(1000, 2000000), tg);
               tame = 1'b1;
            end
            2: program_regs(coef_word(), coef_word(), coef_word(), coef_word(),
                            coef_word(), wide_word());
            default: begin
               if (phase < PhaseCount / 2)
                  program_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h7FFF_FFFF, Min32);
               else
                  program_regs(32'h7FFF_FFFF, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'h7FFF_FFFF,
                               Max32);
            end
         endcase

         // long receiver hold-off while samples keep coming
         if (phase == 1 || phase == 6)
            hold_asks++;

         run_left = 0;
         for (n = 0; n < PhaseBeats; n++) begin
            if (run_left == 0) begin
               // a well-formed run opens with a reinitialise, then observer steps
               run_left = $urandom_range(4, 40);
               offer_beat(make_sample(1'b1, tame));
            end else begin
               run_left--;
               offer_beat(make_sample($urandom_range(0, 19) == 0,
                                      tame && ($urandom_range(0, 9) != 0)));
            end
            // sender holds back until every result is home
            if (phase == PausePhase && n == PhaseBeats / 2) begin
               req_bus.valid <= 1'b0;
               wait_idle();
            end
         end
         req_bus.valid <= 1'b0;
         wait_idle();
      end

      repeat (TailCycles) @(posedge clock);
      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/pnfo_pkg.sv
sv/pnfo_req_if.sv
sv/pnfo_rsp_if.sv
sv/pnfo_alu.sv
sv/pmsm_nonlinear_flux_observer_core.sv
sv/pnfo_checker.sv
tb/sv/pnfo_flux_checker.sv
tb/sv/pmsm_nonlinear_flux_observer_core_test.sv
